FILE: rtl/core/psrf_pkg.sv
`timescale 1ns / 1ps

package psrf_pkg;

  localparam int COORD_BITS  = 24;
  localparam int GUARD_SHIFT = 16;
  // datapath width: coordinate, guard scale, pre-rotation bit and CORDIC gain
  localparam int CW          = COORD_BITS + GUARD_SHIFT + 3;
  localparam int TAB_FRAC    = 20;
  localparam int ZW          = 30;
  localparam int TAB_LEN     = 24;
  localparam int ANGLE_REG_BITS = 18;
  localparam int RANGE_REG_BITS = 24;

  // atan(2^-i) in 2^-20 degree
  localparam logic [26:0] ATAN_TAB [TAB_LEN] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

  localparam logic signed [ZW-1:0] Z180 = ZW'(180 * (1 << TAB_FRAC));

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [31:0]                  intensity_word;
    logic                         coords_finite;
    logic                         cloud_end;
  } in_word_t;

  typedef struct packed {
    logic                         keep;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic [31:0]                  out_intensity;
    logic                         out_cloud_end;
  } out_word_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    in_word_t             word;
  } cordic_data_t;

endpackage

FILE: rtl/core/psrf_cordic_cell.sv
`timescale 1ns / 1ps

module psrf_cordic_cell import psrf_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cordic_data_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output cordic_data_t out_data
);

  logic signed [CW-1:0] x_sh;
  logic signed [CW-1:0] y_sh;
  logic signed [ZW-1:0] step;
  cordic_data_t         nxt;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    x_sh = in_data.x >>> STAGE;
    y_sh = in_data.y >>> STAGE;
    step = signed'(ZW'(ATAN_TAB[STAGE]));
    nxt  = in_data;
    // rotate toward the x axis
    if (in_data.y < 0) begin
      nxt.x = in_data.x - y_sh;
      nxt.y = in_data.y + x_sh;
      nxt.z = in_data.z - step;
    end else begin
      nxt.x = in_data.x + y_sh;
      nxt.y = in_data.y - x_sh;
      nxt.z = in_data.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

FILE: rtl/core/psrf_bound_fold.sv
`timescale 1ns / 1ps

module psrf_bound_fold import psrf_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic signed [ANGLE_REG_BITS-1:0]  angle,
  output logic signed [ANGLE_FRAC_BITS+9:0] folded
);

  localparam int    AW     = ANGLE_FRAC_BITS + 10;
  localparam longint HALF  = 64'(180) << ANGLE_FRAC_BITS;
  localparam longint FULL  = 64'(360) << ANGLE_FRAC_BITS;
  localparam longint NEGLIM = 64'(1) << (ANGLE_REG_BITS - 1);
  localparam longint OFFSET = FULL * ((NEGLIM + FULL - 1) / FULL);
  localparam int    UW     = $clog2(2 * NEGLIM + 2 * FULL);
  localparam int    SH     = 40;
  localparam longint RECIP = ((64'(1) << SH) + FULL - 1) / FULL;
  localparam int    RW     = $clog2(RECIP + 1);
  localparam int    QW     = UW + RW - SH;

  localparam logic [RW-1:0]        RECIP_V = RW'(RECIP);
  localparam logic [UW-1:0]        FULL_V  = UW'(FULL);
  localparam logic signed [UW+1:0] FULL_S  = (UW+2)'(FULL);
  localparam logic signed [UW+1:0] HALF_S  = (UW+2)'(HALF);

  logic signed [UW:0]     u_s;
  logic [UW+RW-1:0]       prod;
  logic [UW-1:0]          u_r;
  logic [QW-1:0]          q_r;
  logic [QW+UW-1:0]       qf;
  logic signed [UW+1:0]   r;
  logic signed [UW+1:0]   r_pos;
  logic signed [UW+1:0]   r_fold;

  // reciprocal estimate of the quotient; may be one too large
  always_comb begin
    u_s  = (UW+1)'(angle) + (UW+1)'(OFFSET);
    prod = u_s[UW-1:0] * RECIP_V;
  end

  always_ff @(posedge clk) begin
    u_r <= u_s[UW-1:0];
    q_r <= prod[UW+RW-1:SH];
  end

  always_comb begin
    qf     = q_r * FULL_V;
    r      = signed'({2'b00, u_r}) - signed'((UW+2)'(qf));
    r_pos  = (r < 0) ? r + FULL_S : r;
    r_fold = (r_pos > HALF_S) ? r_pos - FULL_S : r_pos;
  end

  always_ff @(posedge clk) begin
    folded <= r_fold[AW-1:0];
  end

endmodule

FILE: rtl/core/point_sector_range_filter_top.sv
// Words pass the CORDIC cell chain and the output register to out_valid.
// Throughput: one word per cycle unless the output stalls; each CORDIC cell
// and the output stage carry their own valid bit, so bubbles collapse.
// Sector bounds reach the compare via the config and fold registers.
// Reset (synchronous, rst high): pipeline emptied, registers to defaults.
`timescale 1ns / 1ps

module point_sector_range_filter_top import psrf_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = ANGLE_FRAC_BITS + 10;
  localparam int RSH = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] ROUND_ADD = ZW'(1 << (RSH - 1));
  localparam logic signed [AW-1:0] HALF = AW'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] FULL = AW'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] Q90  = AW'(90 << ANGLE_FRAC_BITS);

  localparam logic [2:0] REG_SECTOR_EN  = 3'd0;
  localparam logic [2:0] REG_SECTOR_MIN = 3'd1;
  localparam logic [2:0] REG_SECTOR_MAX = 3'd2;
  localparam logic [2:0] REG_RANGE_EN   = 3'd3;
  localparam logic [2:0] REG_RANGE_LOW  = 3'd4;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd5;

  logic                             sector_enable;
  logic signed [ANGLE_REG_BITS-1:0] sector_min_angle;
  logic signed [ANGLE_REG_BITS-1:0] sector_max_angle;
  logic                             range_enable;
  logic signed [RANGE_REG_BITS-1:0] range_low;
  logic signed [RANGE_REG_BITS-1:0] range_high;

  logic                             cfg_write;
  logic signed [AW-1:0]             lo_fold;
  logic signed [AW-1:0]             hi_fold;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_enable    <= 1'b0;
      sector_min_angle <= -18'sd46080;
      sector_max_angle <= 18'sd46080;
      range_enable     <= 1'b0;
      range_low        <= '0;
      range_high       <= 24'sd8388607;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_SECTOR_EN:  sector_enable    <= pwdata[0];
        REG_SECTOR_MIN: sector_min_angle <= pwdata[ANGLE_REG_BITS-1:0];
        REG_SECTOR_MAX: sector_max_angle <= pwdata[ANGLE_REG_BITS-1:0];
        REG_RANGE_EN:   range_enable     <= pwdata[0];
        REG_RANGE_LOW:  range_low        <= pwdata[RANGE_REG_BITS-1:0];
        REG_RANGE_HIGH: range_high       <= pwdata[RANGE_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SECTOR_EN:  prdata = {31'b0, sector_enable};
      REG_SECTOR_MIN: prdata = {{(32-ANGLE_REG_BITS){1'b0}}, sector_min_angle};
      REG_SECTOR_MAX: prdata = {{(32-ANGLE_REG_BITS){1'b0}}, sector_max_angle};
      REG_RANGE_EN:   prdata = {31'b0, range_enable};
      REG_RANGE_LOW:  prdata = {{(32-RANGE_REG_BITS){1'b0}}, range_low};
      REG_RANGE_HIGH: prdata = {{(32-RANGE_REG_BITS){1'b0}}, range_high};
      default:        prdata = '0;
    endcase
  end

  psrf_bound_fold #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_fold_min (
    .clk    (clk),
    .angle  (sector_min_angle),
    .folded (lo_fold)
  );

  psrf_bound_fold #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_fold_max (
    .clk    (clk),
    .angle  (sector_max_angle),
    .folded (hi_fold)
  );

  // ---------------- pre-rotation into the right half plane ----------------
  cordic_data_t         prep;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;

  always_comb begin
    px        = CW'(in_word.pos_x) <<< GUARD_SHIFT;
    py        = CW'(in_word.pos_y) <<< GUARD_SHIFT;
    prep.word = in_word;
    if (in_word.pos_x < 0) begin
      prep.x = -px;
      prep.y = -py;
      prep.z = (in_word.pos_y >= 0) ? Z180 : -Z180;
    end else begin
      prep.x = px;
      prep.y = py;
      prep.z = '0;
    end
  end

  // ---------------- CORDIC cell chain ----------------
  logic         c_valid [CORDIC_STAGES];
  logic         c_ready [CORDIC_STAGES];
  cordic_data_t c_data  [CORDIC_STAGES];
  logic         dec_ready;

  assign in_ready = c_ready[0];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    logic         up_valid;
    cordic_data_t up_data;
    logic         dn_ready;

    if (i == 0) begin : g_first
      assign up_valid = in_valid;
      assign up_data  = prep;
    end else begin : g_mid
      assign up_valid = c_valid[i-1];
      assign up_data  = c_data[i-1];
    end

    if (i == CORDIC_STAGES - 1) begin : g_last
      assign dn_ready = dec_ready;
    end else begin : g_inner
      assign dn_ready = c_ready[i+1];
    end

    psrf_cordic_cell #(.STAGE(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (up_valid),
      .in_ready  (c_ready[i]),
      .in_data   (up_data),
      .out_valid (c_valid[i]),
      .out_ready (dn_ready),
      .out_data  (c_data[i])
    );
  end

  // ---------------- decision and output register ----------------
  cordic_data_t                     fin;
  logic signed [ZW-1:0]             z_rnd;
  logic signed [ZW-1:0]             z_sh;
  logic signed [AW-1:0]             az_raw;
  logic signed [AW-1:0]             az;
  logic signed [RANGE_REG_BITS-1:0] rng_lo;
  logic signed [RANGE_REG_BITS-1:0] rng_hi;
  logic                             in_sector;
  logic                             in_range;
  logic                             keep_next;

  assign fin       = c_data[CORDIC_STAGES-1];
  assign dec_ready = !out_valid || out_ready;

  always_comb begin
    z_rnd  = fin.z + ROUND_ADD;
    z_sh   = z_rnd >>> RSH;
    az_raw = z_sh[AW-1:0];
    if (fin.word.pos_y == 0) begin
      az = (fin.word.pos_x < 0) ? HALF : '0;
    end else if (fin.word.pos_x == 0) begin
      az = (fin.word.pos_y > 0) ? Q90 : -Q90;
    end else if (az_raw > HALF) begin
      az = az_raw - FULL;
    end else if (az_raw <= -HALF) begin
      az = az_raw + FULL;
    end else begin
      az = az_raw;
    end

    // min above max means the sector wraps through 180
    if (lo_fold <= hi_fold) begin
      in_sector = (az >= lo_fold) && (az <= hi_fold);
    end else begin
      in_sector = (az >= lo_fold) || (az <= hi_fold);
    end

    rng_lo   = (range_low < range_high) ? range_low : range_high;
    rng_hi   = (range_low < range_high) ? range_high : range_low;
    in_range = (fin.word.pos_x >= rng_lo) && (fin.word.pos_x <= rng_hi);

    if (!sector_enable && !range_enable) begin
      keep_next = 1'b1;
    end else begin
      keep_next = fin.word.coords_finite && (!sector_enable || in_sector)
                  && (!range_enable || in_range);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dec_ready) begin
      out_valid <= c_valid[CORDIC_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (dec_ready && c_valid[CORDIC_STAGES-1]) begin
      out_word.keep          <= keep_next;
      out_word.out_x         <= fin.word.pos_x;
      out_word.out_y         <= fin.word.pos_y;
      out_word.out_z         <= fin.word.pos_z;
      out_word.out_intensity <= fin.word.intensity_word;
      out_word.out_cloud_end <= fin.word.cloud_end;
    end
  end

`ifndef ASSERT_OFF
  // input backpressure only comes from a full chain behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output stall");

  // a new output word must come from the last cell
  a_out_from_chain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(c_valid[CORDIC_STAGES-1]))
    else $error("output word appeared without a word in the last cell");
`endif

endmodule
